// File: src/hbr_pkg.sv
// Shared types, sizes and coefficient tables for the factor-two resampler.
// The coefficient tables are built by constant functions at elaboration.
// No dependencies.
package hbr_pkg;

  // Sizes
  localparam int Taps     = 128;
  localparam int SampleW  = 16;
  localparam int CoefW    = 16;
  localparam int FracBits = CoefW - 1;
  localparam int Depth    = Taps + 1;
  localparam int AddrW    = $clog2(Depth);
  localparam int TapW     = $clog2(Taps);
  localparam int ProdW    = SampleW + CoefW;
  localparam int AccW     = SampleW + CoefW + TapW + 1;
  localparam int DelayTap = Taps / 2;

  // Fixed-point constants for the kernel build (Q30)
  localparam longint Q30One  = 64'sd1073741824;
  localparam longint Alpha   = 64'sd171798692;
  localparam longint HalfQ30 = 64'sd536870912;
  localparam longint A0Q30   = (Q30One - Alpha) / 2;
  localparam longint A2Q30   = Alpha / 2;
  localparam longint InvPi   = 64'sd341782638;
  localparam longint HalfPi  = 64'sd1686629713;
  localparam longint CoefMax = (64'sd1 <<< (CoefW - 1)) - 1;
  localparam longint CoefMin = -CoefMax - 1;

  typedef enum logic {
    MODE_UP   = 1'b0,
    MODE_DOWN = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef struct packed {
    logic                       kind;
    logic signed [SampleW-1:0]  sample;
    logic                       block_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0]  result_sample;
    logic                       last;
  } out_beat_t;

  // Control from the sequencer to the MAC
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // operands valid this cycle
  } mac_ctl_t;

  typedef logic [Taps-1:0][CoefW-1:0] coef_tab_t;

  // Restoring division, unsigned 64 bit
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Signed product shifted right, rounded half away from zero
  function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int sh);
    logic        neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] r;
    neg = a[63] ^ b[63];
    ua  = a[63] ? (64'd0 - a) : a;
    ub  = b[63] ? (64'd0 - b) : b;
    r   = (ua * ub + (64'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  // Taylor series of cos (odd = 0) or sin (odd = 1), angle in Q30 radians
  function automatic logic signed [63:0] series(input logic [63:0] a, input logic odd);
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        d;
    logic [63:0]        dv;
    logic signed [63:0] sum;
    a2   = (a * a + (64'd1 << 29)) >> 30;
    term = odd ? a : 64'(Q30One);
    d    = odd ? 64'd2 : 64'd1;
    sum  = $signed(term);
    for (int k = 1; k <= 7; k++) begin
      dv   = d * (d + 64'd1);
      term = (term * a2 + (64'd1 << 29)) >> 30;
      term = udiv(term + (dv >> 1), dv);
      d    = d + 64'd2;
      if (k[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    return sum;
  endfunction

  // cos(2*pi*p/q) in Q30
  function automatic logic signed [63:0] cos_turn(input logic [63:0] p, input logic [63:0] q);
    logic [63:0]        pm;
    logic [63:0]        ph;
    logic [63:0]        frac;
    logic [63:0]        a;
    logic [1:0]         quad;
    logic signed [63:0] res;
    pm   = p - udiv(p, q) * q;
    ph   = udiv(pm << 32, q) & 64'hFFFF_FFFF;
    quad = ph[31:30];
    frac = {34'd0, ph[29:0]};
    a    = (frac * 64'(HalfPi) + (64'd1 << 29)) >> 30;
    unique case (quad)
      2'd0: res = series(a, 1'b0);
      2'd1: res = -series(a, 1'b1);
      2'd2: res = -series(a, 1'b0);
      2'd3: res = series(a, 1'b1);
    endcase
    return res;
  endfunction

  // Blackman window at p/q, Q30
  function automatic logic signed [63:0] window(input logic [63:0] p, input logic [63:0] q);
    return A0Q30 - mul_round(HalfQ30, cos_turn(p, q), 30)
                 + mul_round(A2Q30, cos_turn(64'd2 * p, q), 30);
  endfunction

  // Q30 sinc times Q30 window to saturated Q15
  function automatic logic [CoefW-1:0] to_coef(input logic signed [63:0] sinc,
                                               input logic signed [63:0] w);
    logic signed [63:0] c;
    c = mul_round(sinc, w, 45);
    if (c > CoefMax) c = CoefMax;
    if (c < CoefMin) c = CoefMin;
    return c[CoefW-1:0];
  endfunction

  // Build the up (dn = 0) or half-band down (dn = 1) kernel
  function automatic coef_tab_t build_coefs(input logic dn);
    coef_tab_t          tab;
    int                 k;
    logic [63:0]        ud;
    logic [63:0]        uk;
    logic               neg_d;
    logic signed [63:0] s;
    for (int i = 0; i < Taps; i++) begin
      k  = i - Taps / 2;
      uk = 64'((k < 0) ? -k : k);
      if (!dn) begin
        neg_d = (k < 0);
        ud    = 64'((2 * k + 1 < 0) ? -(2 * k + 1) : (2 * k + 1));
        s     = $signed(udiv(64'(2 * InvPi) + (ud >> 1), ud));
        if (uk[0] != neg_d) s = -s;
        tab[i] = to_coef(s, window(64'(2 * i + 1), 64'(2 * Taps)));
      end else begin
        if (k == 0) begin
          s = HalfQ30;
        end else if (!uk[0]) begin
          s = '0;
        end else begin
          s = $signed(udiv(64'(InvPi) + (uk >> 1), uk));
          if (uk[1:0] == 2'b11) s = -s;
        end
        tab[i] = to_coef(s, window(64'(2 * i), 64'(2 * Taps)));
      end
    end
    return tab;
  endfunction

  localparam coef_tab_t UpCoef = build_coefs(1'b0);
  localparam coef_tab_t DnCoef = build_coefs(1'b1);

endpackage

// File: src/hbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbr_ram #(
  parameter int Width = 16,
  parameter int Depth = 129
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/hbr_mac.sv
// Shared multiply-accumulate unit with round-half-up and saturation.
// Depends on hbr_pkg.
module hbr_mac import hbr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_ctl_t                  ctl_i,
  input  logic signed [SampleW-1:0] smp_i,
  input  logic signed [CoefW-1:0]   coef_i,
  output logic                      busy_o,
  output logic signed [SampleW-1:0] res_o
);

  localparam int SatMaxI = (1 << (SampleW - 1)) - 1;
  localparam logic signed [AccW:0] SatMax = (AccW + 1)'(SatMaxI);
  localparam logic signed [AccW:0] SatMin = (AccW + 1)'(-SatMaxI - 1);
  localparam logic signed [AccW:0] RndBias = (AccW + 1)'(1 << (FracBits - 1));

  logic                    prod_vld_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW:0]    rnd;
  logic signed [AccW:0]    shd;

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= smp_i * coef_i;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // Round half up, drop fraction, saturate
  always_comb begin
    rnd = (AccW + 1)'(acc_q) + RndBias;
    shd = rnd >>> FracBits;
    if (shd > SatMax)      res_o = SatMax[SampleW-1:0];
    else if (shd < SatMin) res_o = SatMin[SampleW-1:0];
    else                   res_o = shd[SampleW-1:0];
  end

  assign busy_o = prod_vld_q;

endmodule

// File: src/hbr_seq.sv
// Sequencer: history pointer and fill flags, tap walk, delay tap capture
// and result beats. Depends on hbr_pkg.
module hbr_seq import hbr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mode_e                     mode_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  in_beat_t                  in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output out_beat_t                 out_data_o,
  output logic                      we_o,
  output logic [AddrW-1:0]          waddr_o,
  output logic [SampleW-1:0]        wdata_o,
  output logic [AddrW-1:0]          raddr_o,
  input  logic [SampleW-1:0]        rdata_i,
  output mac_ctl_t                  mac_ctl_o,
  output logic signed [SampleW-1:0] mac_smp_o,
  output logic signed [CoefW-1:0]   mac_coef_o,
  input  logic                      mac_busy_i,
  input  logic signed [SampleW-1:0] mac_res_i
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_MAC     = 5'b00010,
    S_DRAIN   = 5'b00100,
    S_OUT_DLY = 5'b01000,
    S_OUT_FIR = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [AddrW-1:0]    wp_q, wp_nxt;
  logic [Depth-1:0]    hv_q;
  logic                phase_q;
  logic [AddrW-1:0]    rd_addr_q, rd_addr_dec;
  logic [TapW-1:0]     tap_q;
  logic                up_q;
  logic                iss_q;
  logic                hv_rd_q;
  logic                dly_tag_q;
  logic [CoefW-1:0]    coef_q;
  logic [SampleW-1:0]  dly_q;
  logic                in_acc;
  logic                is_clr;
  logic                start;
  logic                tap_last;
  logic [SampleW-1:0]  smp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign is_clr      = (in_data_i.kind == KIND_CLEAR);
  assign start       = !is_clr && ((mode_i == MODE_UP) || phase_q);
  assign tap_last    = (tap_q == TapW'(Taps - 1));
  assign wp_nxt      = (wp_q == AddrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
  assign rd_addr_dec = (rd_addr_q == '0) ? AddrW'(Depth - 1) : rd_addr_q - 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc && start) state_d = S_MAC;
      S_MAC:     if (tap_last) state_d = S_DRAIN;
      S_DRAIN:   if (!iss_q && !mac_busy_i) state_d = up_q ? S_OUT_DLY : S_OUT_FIR;
      S_OUT_DLY: if (out_ready_i) state_d = S_OUT_FIR;
      S_OUT_FIR: if (out_ready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      hv_q      <= '0;
      phase_q   <= 1'b0;
      rd_addr_q <= '0;
      tap_q     <= '0;
      up_q      <= 1'b0;
      iss_q     <= 1'b0;
      dly_tag_q <= 1'b0;
      hv_rd_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= (state_q == S_MAC);
      dly_tag_q <= (state_q == S_MAC) && (tap_q == TapW'(DelayTap));
      hv_rd_q   <= hv_q[rd_addr_q];
      // take a beat: clear drops the history, a sample advances it
      if (in_acc) begin
        if (is_clr) begin
          hv_q    <= '0;
          phase_q <= 1'b0;
        end else begin
          hv_q[wp_nxt] <= 1'b1;
          wp_q         <= wp_nxt;
          phase_q      <= (mode_i == MODE_DOWN) && !phase_q && !in_data_i.block_end;
          rd_addr_q    <= (mode_i == MODE_UP) ? wp_nxt : wp_q;
          tap_q        <= '0;
          up_q         <= (mode_i == MODE_UP);
        end
      end else if (state_q == S_MAC) begin
        rd_addr_q <= rd_addr_dec;
        tap_q     <= tap_q + 1'b1;
      end
    end
  end

  // Coefficient fetch and delay tap capture
  always_ff @(posedge clk_i) begin
    coef_q <= up_q ? UpCoef[tap_q] : DnCoef[tap_q];
    if (iss_q && dly_tag_q) begin
      dly_q <= smp;
    end
  end

  // Never-written entries read as zero
  assign smp = hv_rd_q ? rdata_i : '0;

  assign we_o      = in_acc && !is_clr;
  assign waddr_o   = wp_nxt;
  assign wdata_o   = in_data_i.sample;
  assign raddr_o   = rd_addr_q;

  assign mac_ctl_o.clr = in_acc && start;
  assign mac_ctl_o.vld = iss_q;
  assign mac_smp_o     = $signed(smp);
  assign mac_coef_o    = $signed(coef_q);

  // Result beats: delayed sample first in up mode, then the filter output
  assign out_valid_o              = (state_q == S_OUT_DLY) || (state_q == S_OUT_FIR);
  assign out_data_o.result_sample = (state_q == S_OUT_DLY) ? $signed(dly_q) : mac_res_i;
  assign out_data_o.last          = (state_q == S_OUT_FIR);

endmodule

// File: src/halfband_resampler_2x.sv
// Top level of the factor-two resampler: mode register, history RAM,
// sequencer and shared MAC. Depends on hbr_pkg, hbr_ram, hbr_mac, hbr_seq.
//
//   channel | direction | payload    | beat taken when
//   in      | input     | in_beat_t  | in_valid_i  & in_ready_o
//   out     | output    | out_beat_t | out_valid_o & out_ready_i
//   cfg     | input     | mode (1 b) | cfg_valid_i & cfg_ready_o
//
// A sample that produces output is taken in, walks the taps through the single MAC
// (one RAM read per cycle), waits in the drain state until the MAC pipeline is
// empty, then gives one cycle per result beat while out_ready_i is high: two beats
// in up mode and one beat in down mode.
// Clear items and even-position samples in down mode start no tap walk and give no result.
// Reset is asynchronous; history fill flags clear at once, no clearing pass.
// While a result waits for out_ready_i the block holds it and takes no input.
module halfband_resampler_2x import hbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  mode_e                     mode_q;
  logic                      we;
  logic [AddrW-1:0]          waddr;
  logic [SampleW-1:0]        wdata;
  logic [AddrW-1:0]          raddr;
  logic [SampleW-1:0]        rdata;
  mac_ctl_t                  mac_ctl;
  logic signed [SampleW-1:0] mac_smp;
  logic signed [CoefW-1:0]   mac_coef;
  logic                      mac_busy;
  logic signed [SampleW-1:0] mac_res;

  // Mode register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_UP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  hbr_ram #(
    .Width (SampleW),
    .Depth (Depth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hbr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .mac_ctl_o   (mac_ctl),
    .mac_smp_o   (mac_smp),
    .mac_coef_o  (mac_coef),
    .mac_busy_i  (mac_busy),
    .mac_res_i   (mac_res)
  );

  hbr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .smp_i  (mac_smp),
    .coef_i (mac_coef),
    .busy_o (mac_busy),
    .res_o  (mac_res)
  );

  // Input stays closed while a result beat is pending
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input open while a result beat is pending");

  // Accumulator is settled while a result beat is shown
  a_mac_quiet_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!mac_ctl.vld && !mac_busy))
    else $error("MAC active while a result beat is pending");

  // Accumulator clears only when a beat is taken
  a_clr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.clr |-> (in_valid_i && in_ready_o))
    else $error("accumulator cleared without an input beat");

  // After the final beat of an item the input reopens
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last) |=> in_ready_o)
    else $error("input not reopened after final result beat");

endmodule
